// ===== hw/rtl/csw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_pkg
// Shared request, process state and error codes, plus the command and status
// structs between the semaphore controller and its datapath.
// ----------------------------------------------------------------------------
package csw_pkg;

    localparam logic [2:0] REQ_START     = 3'd0;
    localparam logic [2:0] REQ_TERMINATE = 3'd1;
    localparam logic [2:0] REQ_SUSPEND   = 3'd2;
    localparam logic [2:0] REQ_RESUME    = 3'd3;
    localparam logic [2:0] REQ_SIGNAL    = 3'd4;
    localparam logic [2:0] REQ_WAIT      = 3'd5;

    localparam logic [1:0] ST_READY      = 2'd0;
    localparam logic [1:0] ST_RUNNING    = 2'd1;
    localparam logic [1:0] ST_SUSPENDED  = 2'd2;
    localparam logic [1:0] ST_TERMINATED = 2'd3;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_FULL      = 2'd1;
    localparam logic [1:0] ERR_SATURATED = 2'd2;

    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

    typedef struct packed {
        logic capture;
        logic pop;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic pop_need;
        logic out_free;
    } t_status;

endpackage

// ===== hw/rtl/csw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_ctrl
// Sequencer for one request at a time: accept, optional waiter pop, then
// commit into the tables and the output register.
// ----------------------------------------------------------------------------
module csw_ctrl
    import csw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = i_status.pop_need ? S_POP : S_EXEC;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_capture_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state != S_IDLE))
        else $error("capture did not leave idle");

    a_pop_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (r_state == S_EXEC))
        else $error("pop not followed by exec");

endmodule

// ===== hw/rtl/csw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_dp
// Process state memory with valid bits, waiter stack memory, excess signal
// count, waiter total and the result register.
// ----------------------------------------------------------------------------
module csw_dp
    import csw_pkg::*;
#(
    parameter int NUM_PROCS  = 16,
    parameter int WAIT_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [2:0]  i_req,
    input  logic [3:0]  i_id,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic        o_resumed_valid,
    output logic [3:0]  o_resumed_id,
    output logic [1:0]  o_proc_state,
    output logic [15:0] o_excess_count,
    output logic [4:0]  o_waiting_count,
    output logic [1:0]  o_error_code
);

    localparam int PAW = $clog2(NUM_PROCS);
    localparam int WAW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int TW  = $clog2(WAIT_DEPTH + 1);

    logic [1:0]     r_pmem [NUM_PROCS];
    logic [3:0]     r_wmem [WAIT_DEPTH];
    logic [NUM_PROCS-1:0] r_pvalid;

    logic [2:0]     r_req;
    logic [3:0]     r_id;
    logic [PAW-1:0] r_paddr;
    logic           r_pok;
    logic [1:0]     r_pdata;
    logic           r_pvld;
    logic [3:0]     r_wdata;
    logic [15:0]    r_count;
    logic [TW-1:0]  r_total;

    logic           r_ovalid;
    logic           r_orvalid;
    logic [3:0]     r_orid;
    logic [1:0]     r_opstate;
    logic [15:0]    r_ocount;
    logic [TW-1:0]  r_ototal;
    logic [1:0]     r_oerr;

    logic [PAW+3:0] w_in_ext;
    logic [PAW+3:0] w_who_ext;
    logic           w_in_ok;
    logic           w_who_ok;
    logic [PAW-1:0] w_prd_addr;
    logic [TW-1:0]  w_total_m1;
    logic [WAW-1:0] w_wrd_addr;
    logic [TW+4:0]  w_total_ext;
    logic [1:0]     w_ps;

    logic [15:0]    n_count;
    logic [TW-1:0]  n_total;
    logic           n_pwe;
    logic [1:0]     n_pstate_wr;
    logic           n_wwe;
    logic           n_rvalid;
    logic [3:0]     n_rid;
    logic [1:0]     n_pstate;
    logic [1:0]     n_err;

    assign w_in_ext   = {{PAW{1'b0}}, i_id};
    assign w_who_ext  = {{PAW{1'b0}}, r_wdata};
    assign w_in_ok    = w_in_ext < (PAW + 4)'(NUM_PROCS);
    assign w_who_ok   = w_who_ext < (PAW + 4)'(NUM_PROCS);
    assign w_prd_addr = i_cmd.pop ? w_who_ext[PAW-1:0] : w_in_ext[PAW-1:0];
    assign w_total_m1 = r_total - TW'(1);
    assign w_wrd_addr = (r_total == '0) ? '0 : w_total_m1[WAW-1:0];
    assign w_ps       = r_pvld ? r_pdata : ST_READY;

    assign o_status.pop_need = (i_req == REQ_SIGNAL) && (r_total != '0);
    assign o_status.out_free = !r_ovalid || i_out_ready;

    always_comb begin
        n_count     = r_count;
        n_total     = r_total;
        n_pwe       = 1'b0;
        n_pstate_wr = w_ps;
        n_wwe       = 1'b0;
        n_rvalid    = 1'b0;
        n_rid       = 4'd0;
        n_pstate    = ST_READY;
        n_err       = ERR_NONE;
        case (r_req)
            REQ_START, REQ_TERMINATE, REQ_SUSPEND, REQ_RESUME: begin
                if (r_pok) begin
                    case (r_req)
                        REQ_START:     n_pstate_wr = (w_ps == ST_READY) ? ST_RUNNING : w_ps;
                        REQ_TERMINATE: n_pstate_wr = ST_TERMINATED;
                        REQ_SUSPEND:   n_pstate_wr = (w_ps == ST_RUNNING) ? ST_SUSPENDED : w_ps;
                        default:       n_pstate_wr = (w_ps == ST_SUSPENDED) ? ST_RUNNING : w_ps;
                    endcase
                    n_pwe    = 1'b1;
                    n_pstate = n_pstate_wr;
                end
            end
            REQ_SIGNAL: begin
                if (r_total == '0) begin
                    if (r_count == COUNT_MAX) begin
                        n_err = ERR_SATURATED;
                    end else begin
                        n_count = r_count + 16'd1;
                    end
                end else begin
                    n_total  = w_total_m1;
                    n_rvalid = 1'b1;
                    n_rid    = r_wdata;
                    if (r_pok) begin
                        n_pstate_wr = (w_ps == ST_SUSPENDED) ? ST_RUNNING : w_ps;
                        n_pwe       = 1'b1;
                        n_pstate    = n_pstate_wr;
                    end
                end
            end
            REQ_WAIT: begin
                if (r_pok) begin
                    n_pstate = w_ps;
                    if (r_count != 16'd0) begin
                        n_count = r_count - 16'd1;
                    end else if (r_total >= TW'(WAIT_DEPTH)) begin
                        n_err = ERR_FULL;
                    end else begin
                        n_wwe       = 1'b1;
                        n_total     = r_total + TW'(1);
                        n_pstate_wr = (w_ps == ST_RUNNING) ? ST_SUSPENDED : w_ps;
                        n_pwe       = 1'b1;
                        n_pstate    = n_pstate_wr;
                    end
                end
            end
            default: begin
                n_err = ERR_NONE;
            end
        endcase
    end

    // memories and payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture || i_cmd.pop) begin
            r_pdata <= r_pmem[w_prd_addr];
            r_pvld  <= r_pvalid[w_prd_addr];
            r_paddr <= w_prd_addr;
            r_pok   <= i_cmd.pop ? w_who_ok : w_in_ok;
        end
        if (i_cmd.capture) begin
            r_req   <= i_req;
            r_id    <= i_id;
            r_wdata <= r_wmem[w_wrd_addr];
        end
        if (i_cmd.exec && n_pwe) begin
            r_pmem[r_paddr] <= n_pstate_wr;
        end
        if (i_cmd.exec && n_wwe) begin
            r_wmem[r_total[WAW-1:0]] <= r_id;
        end
        if (i_cmd.exec) begin
            r_orvalid <= n_rvalid;
            r_orid    <= n_rid;
            r_opstate <= n_pstate;
            r_ocount  <= n_count;
            r_ototal  <= n_total;
            r_oerr    <= n_err;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= '0;
            r_count  <= 16'd0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_count <= n_count;
                r_total <= n_total;
                if (n_pwe) begin
                    r_pvalid[r_paddr] <= 1'b1;
                end
            end
            if (i_cmd.exec) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign w_total_ext     = {5'd0, r_ototal};
    assign o_out_valid     = r_ovalid;
    assign o_resumed_valid = r_orvalid;
    assign o_resumed_id    = r_orid;
    assign o_proc_state    = r_opstate;
    assign o_excess_count  = r_ocount;
    assign o_waiting_count = w_total_ext[4:0];
    assign o_error_code    = r_oerr;

    a_total_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(WAIT_DEPTH))
        else $error("waiter total beyond depth");

    a_exec_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> (!r_ovalid || i_out_ready))
        else $error("commit while result register is occupied");

    a_full_keeps_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (n_err == ERR_FULL)) |=> $stable(r_total))
        else $error("full wait changed waiter total");

endmodule

// ===== hw/rtl/counting_semaphore_with_waiters.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_with_waiters
// Accept captures the request with a registered read of the process state memory
// and the waiter stack; a popping signal adds a pop state. The result commits once
// the output register is free; no new request is accepted until then.
// Reset clears the state valid bits, counters and handshake; no clearing pass.
// ----------------------------------------------------------------------------
module counting_semaphore_with_waiters
    import csw_pkg::*;
#(
    parameter int NUM_PROCS  = 16,
    parameter int WAIT_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // process_id[3:0], zero pad
    input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // resumed_id[3:0], proc_state_out[5:4],
                                        // excess_count[21:6], waiting_count[26:22],
                                        // error_code[28:27], zero pad
    output logic [0:0]  m_axis_tuser    // resumed_valid[0]
);

    t_cmd        w_cmd;
    t_status     w_status;
    logic        w_rvalid;
    logic [3:0]  w_rid;
    logic [1:0]  w_pstate;
    logic [15:0] w_count;
    logic [4:0]  w_wait;
    logic [1:0]  w_err;

    csw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    csw_dp #(
        .NUM_PROCS  (NUM_PROCS),
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_req           (s_axis_tuser),
        .i_id            (s_axis_tdata[3:0]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_resumed_valid (w_rvalid),
        .o_resumed_id    (w_rid),
        .o_proc_state    (w_pstate),
        .o_excess_count  (w_count),
        .o_waiting_count (w_wait),
        .o_error_code    (w_err)
    );

    assign m_axis_tdata = {3'd0, w_err, w_wait, w_count, w_pstate, w_rid};
    assign m_axis_tuser = w_rvalid;

endmodule
